[rtl/mmml_pkg.sv]
// shared constants, types and helpers for the matrix multiply core
// no dependencies
package mmml_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 35;
  localparam int MUL_W     = 2 * ELEM_W;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SIZE_W    = $clog2(MEM_DEPTH + 1);
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A      = 3'd0,
    REG_INNER_DIM   = 3'd1,
    REG_COLS_B      = 3'd2,
    REG_A_COL_MAJOR = 3'd3,
    REG_B_COL_MAJOR = 3'd4
  } cfg_reg_e;

  // control handed from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic shift_in;
    logic mul;
    logic acc;
    logic shift_out;
  } cell_ctrl_t;

  // clamp a size register into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/mmml_cell.sv]
// one row cell: holds an element of A, a registered product and an accumulator
// depends on mmml_pkg
module mmml_cell import mmml_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  input  logic signed [PROD_W-1:0] acc_i,
  output logic signed [ELEM_W-1:0] a_o,
  output logic signed [PROD_W-1:0] acc_o
);

  logic signed [ELEM_W-1:0] a_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [PROD_W-1:0] acc_q;

  // a element moves up the chain, product registered before the add
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_in) begin
      a_q <= a_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= a_q * b_i;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + {{(PROD_W-MUL_W){prod_q[MUL_W-1]}}, prod_q};
    end else if (ctrl_i.shift_out) begin
      acc_q <= acc_i;
    end
  end

  assign a_o   = a_q;
  assign acc_o = acc_q;

endmodule

[rtl/mmml_chain.sv]
// row of cells: a elements shift up, finished sums shift down to cell 0
// depends on mmml_pkg and mmml_cell
module mmml_chain import mmml_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [ELEM_W-1:0] a_in_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output logic signed [PROD_W-1:0] sum_o
);

  logic signed [ELEM_W-1:0] a_link [MAX_DIM+1];
  logic signed [PROD_W-1:0] acc_link [MAX_DIM+1];

  assign a_link[0]         = a_in_i;
  assign acc_link[MAX_DIM] = '0;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic signed [ELEM_W-1:0] a_out;
    logic signed [PROD_W-1:0] acc_out;

    mmml_cell u_cell (
      .clk_i (clk_i),
      .ctrl_i(ctrl_i),
      .a_i   (a_link[g]),
      .b_i   (b_i),
      .acc_i (acc_link[g+1]),
      .a_o   (a_out),
      .acc_o (acc_out)
    );

    assign a_link[g+1] = a_out;
    assign acc_link[g] = acc_out;
  end

  assign sum_o = acc_link[0];

endmodule

[rtl/matrix_multiply_mixed_layout_core.sv]
// per column of C the sequencer clears the cells, then for each k fetches a column of A into
// the cell chain, waits, multiplies and accumulates, then unloads the sums; the single
// read port of each element memory feeds the cell chain one element per cycle
// an item, load or compute, is accepted only while the sequencer is idle
// reset: async active low, clears sizes to 8, layouts to column-major, load counters to zero
// element memories are not cleared
module matrix_multiply_mixed_layout_core import mmml_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [ELEM_W-1:0] elem_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PROD_W-1:0] prod_value_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic                     last_elem_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COL   = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  rows_a_q, inner_dim_q, cols_b_q;
  logic              a_col_major_q, b_col_major_q;
  logic [ADDR_W-1:0] count_a_q, count_b_q;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic              shift_pend_q;

  logic [DIM_W-1:0]  m_eff, n_eff, p_eff;
  logic              i_last, j_last, k_last, i_zero;

  assign m_eff  = eff_dim(rows_a_q);
  assign n_eff  = eff_dim(inner_dim_q);
  assign p_eff  = eff_dim(cols_b_q);
  assign i_last = DIM_W'(i_q) == m_eff - DIM_W'(1);
  assign j_last = DIM_W'(j_q) == p_eff - DIM_W'(1);
  assign k_last = DIM_W'(k_q) == n_eff - DIM_W'(1);
  assign i_zero = i_q == '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q      <= CFG_W'(MAX_DIM);
      inner_dim_q   <= CFG_W'(MAX_DIM);
      cols_b_q      <= CFG_W'(MAX_DIM);
      a_col_major_q <= 1'b1;
      b_col_major_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_A:      rows_a_q      <= cfg_data_i;
        REG_INNER_DIM:   inner_dim_q   <= cfg_data_i;
        REG_COLS_B:      cols_b_q      <= cfg_data_i;
        REG_A_COL_MAJOR: a_col_major_q <= cfg_data_i[0];
        REG_B_COL_MAJOR: b_col_major_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input handshake and op decode
  logic in_acc, ld_a, ld_b, start;
  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign ld_a       = in_acc && op_i == OP_LOAD_A;
  assign ld_b       = in_acc && op_i == OP_LOAD_B;
  assign start      = in_acc && op_i == OP_COMPUTE;

  // load positions, wrapping after a full matrix
  logic [SIZE_W-1:0] size_a, size_b, pos_a, pos_b, nxt_a, nxt_b;
  assign size_a = SIZE_W'(m_eff) * SIZE_W'(n_eff);
  assign size_b = SIZE_W'(n_eff) * SIZE_W'(p_eff);
  assign pos_a  = (SIZE_W'(count_a_q) >= size_a) ? '0 : SIZE_W'(count_a_q);
  assign pos_b  = (SIZE_W'(count_b_q) >= size_b) ? '0 : SIZE_W'(count_b_q);
  assign nxt_a  = (pos_a + SIZE_W'(1) >= size_a) ? '0 : pos_a + SIZE_W'(1);
  assign nxt_b  = (pos_b + SIZE_W'(1) >= size_b) ? '0 : pos_b + SIZE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      if (ld_a) begin
        count_a_q <= nxt_a[ADDR_W-1:0];
      end
      if (ld_b) begin
        count_b_q <= nxt_b[ADDR_W-1:0];
      end
    end
  end

  // read addresses under the current layouts
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  assign rd_addr_a = a_col_major_q ?
                     ADDR_W'(i_q) + ADDR_W'(k_q) * ADDR_W'(m_eff) :
                     ADDR_W'(i_q) * ADDR_W'(n_eff) + ADDR_W'(k_q);
  assign rd_addr_b = b_col_major_q ?
                     ADDR_W'(k_q) + ADDR_W'(j_q) * ADDR_W'(n_eff) :
                     ADDR_W'(k_q) * ADDR_W'(p_eff) + ADDR_W'(j_q);

  logic rd_en_a, rd_en_b;
  assign rd_en_a = state_q == S_FETCH;
  assign rd_en_b = state_q == S_FETCH && i_last;

  // element memories, registered reads
  logic signed [ELEM_W-1:0] mem_a [MEM_DEPTH];
  logic signed [ELEM_W-1:0] mem_b [MEM_DEPTH];
  logic signed [ELEM_W-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      mem_a[pos_a[ADDR_W-1:0]] <= elem_value_i;
    end
    if (rd_en_a) begin
      rd_a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      mem_b[pos_b[ADDR_W-1:0]] <= elem_value_i;
    end
    if (rd_en_b) begin
      rd_b_q <= mem_b[rd_addr_b];
    end
  end

  // output register
  logic out_load;
  assign out_load = state_q == S_DRAIN && (!out_valid_o || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          j_d     = '0;
          state_d = S_COL;
        end
      end
      S_COL: begin
        k_d     = '0;
        i_d     = IDX_W'(m_eff - DIM_W'(1));
        state_d = S_FETCH;
      end
      S_FETCH: begin
        if (i_zero) begin
          state_d = S_WAIT;
        end else begin
          i_d = i_q - IDX_W'(1);
        end
      end
      S_WAIT: state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        if (k_last) begin
          i_d     = '0;
          state_d = S_DRAIN;
        end else begin
          k_d     = k_q + IDX_W'(1);
          i_d     = IDX_W'(m_eff - DIM_W'(1));
          state_d = S_FETCH;
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          if (i_last) begin
            if (j_last) begin
              state_d = S_IDLE;
            end else begin
              j_d     = j_q + IDX_W'(1);
              state_d = S_COL;
            end
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      shift_pend_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      shift_pend_q <= rd_en_a;
    end
  end

  // cell chain
  cell_ctrl_t               ctrl;
  logic signed [PROD_W-1:0] sum;

  assign ctrl.clear     = state_q == S_COL;
  assign ctrl.shift_in  = shift_pend_q;
  assign ctrl.mul       = state_q == S_MUL;
  assign ctrl.acc       = state_q == S_ACC;
  assign ctrl.shift_out = out_load;

  mmml_chain u_chain (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .a_in_i(rd_a_q),
    .b_i   (rd_b_q),
    .sum_o (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      prod_value_o <= sum;
      out_row_o    <= i_q;
      out_col_o    <= j_q;
      last_elem_o  <= i_last && j_last;
    end
  end

`ifndef ASSERT_OFF
  // the final element ends the compute
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && i_last && j_last |=> state_q == S_IDLE)
    else $error("sequencer not idle after final element");

  // a compute item starts a column
  a_start_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == S_COL)
    else $error("compute item did not start a column");

  // multiply only after the chain has been filled
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> $past(state_q) == S_WAIT)
    else $error("multiply step out of order");
`endif

endmodule

[sim/matrix_multiply_mixed_layout_core_tb.sv]
// self-checking testbench for the matrix multiply core: loads, computes and checks every
// product element against a behavioural predictor held in a small scoreboard class
// depends on rtl/mmml_pkg.sv and rtl/matrix_multiply_mixed_layout_core.sv
`timescale 1ns / 100ps

module matrix_multiply_mixed_layout_core_tb;
  import mmml_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET = 250;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct {
    logic signed [PROD_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
  } product_t;

  // mirror of the core: registers, element stores, load positions and pending products
  class product_scoreboard;
    logic [CFG_W-1:0]         rows_a, inner_dim, cols_b;
    logic                     a_col_major, b_col_major;
    logic signed [ELEM_W-1:0] elem_a [MEM_DEPTH];
    logic signed [ELEM_W-1:0] elem_b [MEM_DEPTH];
    bit                       written_a [MEM_DEPTH];
    bit                       written_b [MEM_DEPTH];
    int                       pos_a, pos_b;
    product_t                 pending_q [$];

    function new();
      rows_a = 4'd8; inner_dim = 4'd8; cols_b = 4'd8;
      a_col_major = 1'b1; b_col_major = 1'b1;
      pos_a = 0; pos_b = 0;
      foreach (written_a[i]) begin
        written_a[i] = 0;
        written_b[i] = 0;
      end
    endfunction

    function int clamp(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ROWS_A:      rows_a = val;
        REG_INNER_DIM:   inner_dim = val;
        REG_COLS_B:      cols_b = val;
        REG_A_COL_MAJOR: a_col_major = val[0];
        REG_B_COL_MAJOR: b_col_major = val[0];
        default: ;
      endcase
    endfunction

    function int size_a();
      return clamp(rows_a) * clamp(inner_dim);
    endfunction

    function int size_b();
      return clamp(inner_dim) * clamp(cols_b);
    endfunction

    // a compute reads the first m*n and n*p entries of each store
    function bit stores_filled();
      for (int i = 0; i < size_a(); i++) if (!written_a[i]) return 0;
      for (int i = 0; i < size_b(); i++) if (!written_b[i]) return 0;
      return 1;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    function void note_item(op_e op, logic signed [ELEM_W-1:0] val);
      int m, n, p, ia, ib;
      longint sum;
      product_t r;
      m = clamp(rows_a);
      n = clamp(inner_dim);
      p = clamp(cols_b);
      case (op)
        OP_LOAD_A: begin
          if (pos_a >= m * n) pos_a = 0;
          elem_a[pos_a] = val;
          written_a[pos_a] = 1;
          pos_a++;
          if (pos_a >= m * n) pos_a = 0;
        end
        OP_LOAD_B: begin
          if (pos_b >= n * p) pos_b = 0;
          elem_b[pos_b] = val;
          written_b[pos_b] = 1;
          pos_b++;
          if (pos_b >= n * p) pos_b = 0;
        end
        OP_COMPUTE: begin
          // column-major walk over C, row fastest
          for (int j = 0; j < p; j++) begin
            for (int i = 0; i < m; i++) begin
              sum = 0;
              for (int k = 0; k < n; k++) begin
                ia = a_col_major ? (i + k * m) : (i * n + k);
                ib = b_col_major ? (k + j * n) : (k * p + j);
                sum += longint'(elem_a[ia]) * longint'(elem_b[ib]);
              end
              r.value = sum[PROD_W-1:0];
              r.row = i[IDX_W-1:0];
              r.col = j[IDX_W-1:0];
              r.last = (i == m - 1) && (j == p - 1);
              pending_q.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // returns an empty string on a match, else the differing fields
    function string check_result(logic signed [PROD_W-1:0] value, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] col, logic last);
      product_t e;
      string msg;
      e = pending_q.pop_front();
      msg = "";
      if (value !== e.value)
        msg = {msg, $sformatf(" value got %0d exp %0d", value, e.value)};
      if (row !== e.row) msg = {msg, $sformatf(" row got %0d exp %0d", row, e.row)};
      if (col !== e.col) msg = {msg, $sformatf(" col got %0d exp %0d", col, e.col)};
      if (last !== e.last) msg = {msg, $sformatf(" last got %0b exp %0b", last, e.last)};
      return msg;
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i;
  logic signed [ELEM_W-1:0] elem_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [PROD_W-1:0] prod_value_o;
  logic [IDX_W-1:0]         out_row_o;
  logic [IDX_W-1:0]         out_col_o;
  logic                     last_elem_o;

  product_scoreboard book;
  int errors;
  int items_sent;
  int cycles;
  int send_idle;
  int recv_idle;

  matrix_multiply_mixed_layout_core u_top (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d:%s", cycles, msg);
    errors++;
  endtask

  // idling regime follows progress through the stimulus
  always @(posedge clk_i) begin
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle <= 19; recv_idle <= 70;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle <= 70; recv_idle <= 19;
    end else begin
      send_idle <= 0; recv_idle <= 0;
    end
  end

  // receive side: check accepted results, then pick the next ready
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (book.outstanding() == 0) begin
        report_mismatch(" result with no expected product waiting");
      end else begin
        msg = book.check_result(prod_value_o, out_row_o, out_col_o, last_elem_o);
        if (msg != "") report_mismatch(msg);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one item, held until accepted; valid is lowered only for an idle gap
  task automatic send_item(op_e op, logic signed [ELEM_W-1:0] val);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    elem_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_item(op, val);
    items_sent++;
  endtask

  task automatic drain();
    while (book.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, only once the core has gone quiet
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_valid_i <= 1'b0;
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    book.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(int m, int n, int p, bit a_cm, bit b_cm);
    write_reg(REG_ROWS_A, CFG_W'(m));
    write_reg(REG_INNER_DIM, CFG_W'(n));
    write_reg(REG_COLS_B, CFG_W'(p));
    write_reg(REG_A_COL_MAJOR, CFG_W'(a_cm));
    write_reg(REG_B_COL_MAJOR, CFG_W'(b_cm));
  endtask

  // element values lean towards the extremes
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // a whole operand, with an optional fixed value
  task automatic load_operand(op_e op, int count, bit fixed, logic signed [ELEM_W-1:0] val);
    for (int i = 0; i < count; i++) send_item(op, fixed ? val : pick_elem());
  endtask

  // pick a size, mostly small, sometimes out of range
  function automatic int pick_size();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(9, 15);
      2: return 8;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // stimulus
  initial begin
    int phase;
    logic signed [ELEM_W-1:0] dir_a [6];
    logic signed [ELEM_W-1:0] dir_b [6];
    book = new();
    errors = 0;
    items_sent = 0;
    cycles = 0;
    send_idle = 19;
    recv_idle = 70;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = OP_NONE;
    elem_value_i = '0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 2x3 row-major A times 3x2 column-major B, extreme elements
    dir_a = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh5555};
    dir_b = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'shffff, 16'shaaaa, 16'sh0001};
    set_shape(2, 3, 2, 1'b0, 1'b1);
    write_reg(CFG_IDX_UNUSED, 4'hf);
    foreach (dir_a[i]) send_item(OP_LOAD_A, dir_a[i]);
    foreach (dir_b[i]) send_item(OP_LOAD_B, dir_b[i]);
    send_item(OP_NONE, 16'sh7fff);
    send_item(OP_COMPUTE, 16'sh8000);
    // same stores read again under swapped layouts
    write_reg(REG_A_COL_MAJOR, 4'h1);
    write_reg(REG_B_COL_MAJOR, 4'h0);
    send_item(OP_COMPUTE, 16'sh0000);

    // random phases, first two at the size extremes
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        set_shape(1, 1, 1, 1'b0, 1'b0);
      end else if (phase == 1) begin
        // largest sum: every element at the negative extreme
        set_shape(8, 8, 8, 1'b1, 1'b1);
        load_operand(OP_LOAD_A, book.size_a(), 1'b1, 16'sh8000);
        load_operand(OP_LOAD_B, book.size_b(), 1'b1, 16'sh8000);
        send_item(OP_COMPUTE, pick_elem());
      end else begin
        set_shape(pick_size(), pick_size(), pick_size(), $urandom_range(1), $urandom_range(1));
      end
      // the full-size phase is already long enough on its own
      repeat ((phase == 1) ? 0 : $urandom_range(1, 3)) begin
        if (items_sent >= ITEM_TARGET) break;
        // noise: unused op or a partial load that leaves a counter mid-way
        if ($urandom_range(3) == 0) send_item(OP_NONE, pick_elem());
        if ($urandom_range(3) == 0)
          send_item($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B, pick_elem());
        if ($urandom_range(4) != 0 || !book.stores_filled()) begin
          load_operand(OP_LOAD_A, book.size_a(), 1'b0, '0);
          load_operand(OP_LOAD_B, book.size_b(), 1'b0, '0);
        end
        send_item(OP_COMPUTE, pick_elem());
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mmml_pkg.sv
rtl/mmml_cell.sv
rtl/mmml_chain.sv
rtl/matrix_multiply_mixed_layout_core.sv
sim/matrix_multiply_mixed_layout_core_tb.sv
